FILE: rtl/core/bfcd_pkg.sv
// Shared types, constants and register codes of the block frame change detector.
package bfcd_pkg;

  localparam int CHAN_W      = 8;
  localparam int COORD_W     = 12;
  localparam int DIM_W       = 13;
  localparam int TS_W        = 9;
  localparam int CIT_W       = 8;
  localparam int COUNT_W     = 17;
  localparam int SCORE_W     = 17;
  localparam int TILES       = 256;
  localparam int TILE_IDX_W  = $clog2(TILES);
  localparam int QUEUE_DEPTH = 4;
  localparam int QLEVEL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [DIM_W-1:0]   MAX_DIM     = DIM_W'(4096);
  localparam logic [TS_W-1:0]    TS_MIN      = TS_W'(16);
  localparam logic [TS_W-1:0]    TS_MAX      = TS_W'(256);
  localparam logic [SCORE_W-1:0] SCORE_ONE   = SCORE_W'(65536);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam int                 ROUND_HALF  = 32768;
  localparam int                 SCORE_FRAC  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SCORE    = CFG_IDX_W'(4);

  typedef struct packed {
    logic [CHAN_W-1:0] old_red;
    logic [CHAN_W-1:0] old_green;
    logic [CHAN_W-1:0] old_blue;
    logic [CHAN_W-1:0] new_red;
    logic [CHAN_W-1:0] new_green;
    logic [CHAN_W-1:0] new_blue;
  } pix_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] tile_left;
    logic [COORD_W-1:0] tile_top;
    logic [DIM_W-1:0]   tile_right;
    logic [DIM_W-1:0]   tile_bottom;
    logic [COUNT_W-1:0] changed_pixels;
    logic               tile_dirty;
    logic               frame_done;
  } tile_item_t;

  // Settings held already saturated into their working ranges
  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [TS_W-1:0]    tile_size;
    logic [CHAN_W-1:0]  channel_threshold;
    logic [SCORE_W-1:0] min_score_q16;
  } cfg_t;

  // Completed tile on its way from the counting front to the scoring back
  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [DIM_W-1:0]   right;
    logic [DIM_W-1:0]   bottom;
    logic [COUNT_W-1:0] count;
    logic               frame_done;
  } tile_rec_t;

endpackage

FILE: rtl/core/bfcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bfcd_front.sv
// Front part: pixel acceptance, change test, raster counters and per-column counts.
module bfcd_front (
  input  logic                               clk,
  input  logic                               rst,
  input  bfcd_pkg::cfg_t                     cfg,
  input  logic                               pix_valid,
  output logic                               pix_stall,
  input  bfcd_pkg::pix_item_t                pix,
  input  logic [bfcd_pkg::QLEVEL_W-1:0]      q_level,
  output logic                               push,
  output bfcd_pkg::tile_rec_t                rec
);
  import bfcd_pkg::*;

  logic [COORD_W-1:0]    pixel_column, pixel_line;
  logic [CIT_W-1:0]      column_in_tile, line_in_tile;
  logic [TILE_IDX_W-1:0] tile_column_index;

  logic                  accept;
  logic                  changed, line_end, frame_end, tcol_end, trow_end, line_last;
  logic [DIM_W-1:0]      col_inc, line_inc;
  logic [TS_W-1:0]       cit_inc, lit_inc;
  logic [COORD_W-1:0]    left, top;

  logic                  s1_vld, s1_changed, s1_emit;
  logic [TILE_IDX_W-1:0] s1_idx;
  tile_rec_t             s1_rec;

  logic                  last_vld;
  logic [TILE_IDX_W-1:0] last_idx;
  logic [COUNT_W-1:0]    last_val;
  logic [TILES-1:0]      entry_valid;

  logic [COUNT_W-1:0]    rdata, base, incr, wdata;

  function automatic logic over_thr(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                    logic [CHAN_W-1:0] thr);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return d > thr;
  endfunction

  // Leave room for the tile that may still sit in the count stage
  assign pix_stall = q_level >= QLEVEL_W'(QUEUE_DEPTH - 1);
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    changed   = over_thr(pix.old_red,   pix.new_red,   cfg.channel_threshold) ||
                over_thr(pix.old_green, pix.new_green, cfg.channel_threshold) ||
                over_thr(pix.old_blue,  pix.new_blue,  cfg.channel_threshold);
    col_inc   = {1'b0, pixel_column} + DIM_W'(1);
    line_inc  = {1'b0, pixel_line} + DIM_W'(1);
    cit_inc   = {1'b0, column_in_tile} + TS_W'(1);
    lit_inc   = {1'b0, line_in_tile} + TS_W'(1);
    line_end  = col_inc >= cfg.frame_width;
    line_last = line_inc >= cfg.frame_height;
    frame_end = line_end && line_last;
    tcol_end  = line_end || (cit_inc >= cfg.tile_size);
    trow_end  = line_last || (lit_inc >= cfg.tile_size);
    left      = ({4'b0, column_in_tile} > pixel_column) ? '0
                : pixel_column - {4'b0, column_in_tile};
    top       = ({4'b0, line_in_tile} > pixel_line) ? '0
                : pixel_line - {4'b0, line_in_tile};
  end

  // Raster counters and count-stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_column      <= '0;
      pixel_line        <= '0;
      column_in_tile    <= '0;
      line_in_tile      <= '0;
      tile_column_index <= '0;
      s1_vld            <= 1'b0;
    end else begin
      s1_vld <= accept;
      if (accept) begin
        if (line_end) begin
          pixel_column      <= '0;
          column_in_tile    <= '0;
          tile_column_index <= '0;
          if (frame_end) begin
            pixel_line   <= '0;
            line_in_tile <= '0;
          end else begin
            pixel_line   <= line_inc[COORD_W-1:0];
            line_in_tile <= (lit_inc >= cfg.tile_size) ? '0 : lit_inc[CIT_W-1:0];
          end
        end else begin
          pixel_column <= col_inc[COORD_W-1:0];
          if (tcol_end) begin
            column_in_tile <= '0;
            if (tile_column_index != TILE_IDX_W'(TILES - 1)) begin
              tile_column_index <= tile_column_index + TILE_IDX_W'(1);
            end
          end else begin
            column_in_tile <= cit_inc[CIT_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_changed        <= changed;
      s1_emit           <= tcol_end && trow_end;
      s1_idx            <= tile_column_index;
      s1_rec.left       <= left;
      s1_rec.top        <= top;
      s1_rec.right      <= col_inc;
      s1_rec.bottom     <= line_inc;
      s1_rec.count      <= '0;
      s1_rec.frame_done <= frame_end;
    end
  end

  bfcd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TILES)
  ) u_counts (
    .clk   (clk),
    .we    (s1_vld),
    .waddr (s1_idx),
    .wdata (wdata),
    .raddr (tile_column_index),
    .rdata (rdata)
  );

  // Forward the latest write; an entry never written reads as zero
  always_comb begin
    if (last_vld && last_idx == s1_idx) begin
      base = last_val;
    end else if (entry_valid[s1_idx]) begin
      base = rdata;
    end else begin
      base = '0;
    end
    incr  = (s1_changed && base != COUNT_MAX) ? base + COUNT_W'(1) : base;
    wdata = s1_emit ? '0 : incr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_vld    <= 1'b0;
      entry_valid <= '0;
    end else if (s1_vld) begin
      last_vld            <= 1'b1;
      entry_valid[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld) begin
      last_idx <= s1_idx;
      last_val <= wdata;
    end
  end

  always_comb begin
    rec       = s1_rec;
    rec.count = incr;
  end

  assign push = s1_vld && s1_emit;

endmodule

FILE: rtl/core/bfcd_queue.sv
// Short queue of completed tiles between the front and back parts.
module bfcd_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bfcd_pkg::tile_rec_t           push_data,
  input  logic                          pop,
  output bfcd_pkg::tile_rec_t           head,
  output logic                          empty,
  output logic [bfcd_pkg::QLEVEL_W-1:0] level
);
  import bfcd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  tile_rec_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic             do_pop;

  assign empty  = level == '0;
  assign do_pop = pop && !empty;
  assign head   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + PTR_W'(1);
      end
      if (do_pop) begin
        rptr <= rptr + PTR_W'(1);
      end
      level <= level + QLEVEL_W'(push) - QLEVEL_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

FILE: rtl/core/bfcd_back.sv
// Back part: tile area, rounded score limit and the result register.
module bfcd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bfcd_pkg::SCORE_W-1:0]  min_score_q16,
  input  logic                          q_empty,
  input  bfcd_pkg::tile_rec_t           q_head,
  output logic                          q_pop,
  output logic                          tile_valid,
  input  logic                          tile_stall,
  output bfcd_pkg::tile_item_t          tile
);
  import bfcd_pkg::*;

  localparam int AREA_W = 2 * TS_W;
  localparam int PROD_W = COUNT_W + SCORE_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int LIM_W  = SUM_W - SCORE_FRAC;

  logic               advance;
  logic [DIM_W-1:0]   dx_full, dy_full;
  logic [AREA_W-1:0]  area_full;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum;

  logic               b1_vld, b2_vld;
  tile_rec_t          b1_rec, b2_rec;
  logic [COUNT_W-1:0] b1_area;
  logic [LIM_W-1:0]   b2_limit;

  // Hold every stage while the result waits to be taken
  assign advance = !(tile_valid && tile_stall);
  assign q_pop   = advance && !q_empty;

  always_comb begin
    dx_full   = q_head.right - {1'b0, q_head.left};
    dy_full   = q_head.bottom - {1'b0, q_head.top};
    area_full = dx_full[TS_W-1:0] * dy_full[TS_W-1:0];
    prod      = PROD_W'(b1_area) * PROD_W'(min_score_q16);
    sum       = SUM_W'(prod) + SUM_W'(ROUND_HALF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_vld     <= 1'b0;
      b2_vld     <= 1'b0;
      tile_valid <= 1'b0;
    end else if (advance) begin
      b1_vld     <= !q_empty;
      b2_vld     <= b1_vld;
      tile_valid <= b2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1_rec              <= q_head;
      b1_area             <= area_full[COUNT_W-1:0];
      b2_rec              <= b1_rec;
      b2_limit            <= sum[SUM_W-1:SCORE_FRAC];
      tile.tile_left      <= b2_rec.left;
      tile.tile_top       <= b2_rec.top;
      tile.tile_right     <= b2_rec.right;
      tile.tile_bottom    <= b2_rec.bottom;
      tile.changed_pixels <= b2_rec.count;
      tile.tile_dirty     <= LIM_W'(b2_rec.count) > b2_limit;
      tile.frame_done     <= b2_rec.frame_done;
    end
  end

endmodule

FILE: rtl/core/block_frame_change_detector_core.sv
// Top level of the block frame change detector: settings, front, queue and back.
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------
//   pix     | in        | pix_valid/stall   | previous and current RGB pixel pair
//   tile    | out       | tile_valid/stall  | tile bounds, count, dirty, frame end
//   cfg     | in        | cfg_valid/ready   | register index and write data
//
// One pixel pair is taken every cycle unless pix_stall is high; the raster
// counters and the read-modify-write of the per-column count store sustain it.
// A tile result passes the count stage, the tile queue and the back stages.
// Reset clears the count store's valid bits at once; there is no clearing pass.
// A stalled result holds the back part; the four-entry tile queue then fills
// and the pixel channel stalls once the queue has one free slot or none left.
module block_frame_change_detector_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pix_valid,
  output logic                             pix_stall,
  input  bfcd_pkg::pix_item_t              pix,
  output logic                             tile_valid,
  input  logic                             tile_stall,
  output bfcd_pkg::tile_item_t             tile,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bfcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bfcd_pkg::*;

  cfg_t                cfg;
  logic                push, q_pop, q_empty;
  tile_rec_t           push_rec, q_head;
  logic [QLEVEL_W-1:0] q_level;
  logic [DIM_W-1:0]    wr_dim;
  logic [TS_W-1:0]     wr_ts;
  logic [SCORE_W-1:0]  wr_score;

  // Settings are always writable
  assign cfg_ready = 1'b1;

  // Saturate sizes, tile size and minimum score into their ranges as they are written
  always_comb begin
    wr_dim = cfg_data[DIM_W-1:0];
    if (wr_dim == '0) begin
      wr_dim = DIM_W'(1);
    end else if (wr_dim > MAX_DIM) begin
      wr_dim = MAX_DIM;
    end
    wr_ts = cfg_data[TS_W-1:0];
    if (wr_ts < TS_MIN) begin
      wr_ts = TS_MIN;
    end else if (wr_ts > TS_MAX) begin
      wr_ts = TS_MAX;
    end
    wr_score = cfg_data[SCORE_W-1:0];
    if (wr_score > SCORE_ONE) begin
      wr_score = SCORE_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width       <= DIM_W'(640);
      cfg.frame_height      <= DIM_W'(480);
      cfg.tile_size         <= TS_W'(16);
      cfg.channel_threshold <= CHAN_W'(16);
      cfg.min_score_q16     <= SCORE_W'(6554);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg.frame_width       <= wr_dim;
        REG_FRAME_HEIGHT: cfg.frame_height      <= wr_dim;
        REG_TILE_SIZE:    cfg.tile_size         <= wr_ts;
        REG_THRESHOLD:    cfg.channel_threshold <= cfg_data[CHAN_W-1:0];
        REG_MIN_SCORE:    cfg.min_score_q16     <= wr_score;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Count changed pixels and hand each completed tile to the queue
  bfcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .q_level   (q_level),
    .push      (push),
    .rec       (push_rec)
  );

  bfcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_rec),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .level     (q_level)
  );

  // Score each tile against its rounded area limit and present the result
  bfcd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .min_score_q16 (cfg.min_score_q16),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .tile_valid    (tile_valid),
    .tile_stall    (tile_stall),
    .tile          (tile)
  );

  // The queue must never take more tiles than it holds
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= QLEVEL_W'(QUEUE_DEPTH))
    else $error("tile queue overflow");

  // A result always spans at least one column and one line
  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    tile_valid |-> (tile.tile_right > {1'b0, tile.tile_left}) &&
                   (tile.tile_bottom > {1'b0, tile.tile_top}))
    else $error("tile bounds out of order");

  // A tile is never wider or taller than the largest tile edge
  a_tile_extent: assert property (@(posedge clk) disable iff (rst)
    tile_valid |-> (tile.tile_right - {1'b0, tile.tile_left} <= DIM_W'(TS_MAX)) &&
                   (tile.tile_bottom - {1'b0, tile.tile_top} <= DIM_W'(TS_MAX)))
    else $error("tile extent above maximum edge");

endmodule
